>>> hdl/lbbc_pkg.sv
package lbbc_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int BUCKETS_DEF     = 8;
    localparam int DEVICE_BITS_DEF = 8;
    localparam int HASH_MULT       = 31;

    localparam logic [2:0] FN_READ  = 3'd0;
    localparam logic [2:0] FN_ALLOC = 3'd1;
    localparam logic [2:0] FN_WBACK = 3'd2;
    localparam logic [2:0] FN_REL   = 3'd3;
    localparam logic [2:0] FN_DIRTY = 3'd4;

    localparam logic [1:0] KIND_ANS  = 2'd0;
    localparam logic [1:0] KIND_RD   = 2'd1;
    localparam logic [1:0] KIND_WR   = 2'd2;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_ALLOC  = 3'd2;
    localparam logic [2:0] ST_NOFREE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    typedef enum logic [2:0] {
        SRC_IN_E,
        SRC_IN_Z,
        SRC_TAG_E,
        SRC_TAG_IDX,
        SRC_IDX_Z,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        logic       load_in;
        logic       hash_tag;
        logic       hash_step;
        logic       find_init;
        logic       rm_walk_init;
        logic       walk_chain;
        logic       walk_lru;
        logic       vic_init;
        logic       vic_pass2;
        logic       take_p;
        logic       set_valid;
        logic       set_busy;
        logic       lru_head;
        logic       op_apply;
        logic       rm_head;
        logic       rm_link;
        logic       retag;
        logic       emit;
        logic [1:0] kind;
        logic [2:0] status;
        logic       last;
        t_src       src;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       hash_last;
        logic       p_nil;
        logic       match;
        logic       vic_ok;
        logic       pass;
        logic       e_valid;
        logic       e_dirty;
        logic       e_in_table;
        logic       head_is_e;
        logic       next_is_e;
        logic       idx_oob;
        logic       idx_dirty;
    } t_sts;

endpackage

>>> hdl/lbbc_ctrl.sv
module lbbc_ctrl
    import lbbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic i_m_tready,
    output logic o_m_tvalid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_BAD, S_OP, S_OPANS, S_HASH, S_FINIT, S_FIND, S_HIT,
        S_VINIT, S_VSCAN, S_NOFREE, S_VDIRTY, S_VTAB, S_RHASH, S_RHEAD,
        S_RWALK, S_RETAG, S_VLRU, S_ANS
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_cmd.src = SRC_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_hit   = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.func == FN_READ || i_sts.func == FN_ALLOC) begin
                    n_state = S_HASH;
                end else if (i_sts.func == FN_WBACK || i_sts.func == FN_REL ||
                             i_sts.func == FN_DIRTY) begin
                    n_state = S_OP;
                end else begin
                    n_state = S_BAD;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_ANS;
                    o_cmd.status = ST_DONE;
                    o_cmd.last   = 1'b1;
                    o_cmd.src    = SRC_ZERO;
                    n_state = S_IDLE;
                end
            end
            S_OP: begin
                if (i_sts.idx_oob) begin
                    if (out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.kind   = KIND_ANS;
                        o_cmd.status = ST_DONE;
                        o_cmd.last   = 1'b1;
                        o_cmd.src    = SRC_IDX_Z;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.func == FN_WBACK && i_sts.idx_dirty) begin
                    if (out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = KIND_WR;
                        o_cmd.status   = ST_HIT;
                        o_cmd.src      = SRC_TAG_IDX;
                        o_cmd.op_apply = 1'b1;
                        n_state = S_OPANS;
                    end
                end else begin
                    o_cmd.op_apply = 1'b1;
                    n_state = S_OPANS;
                end
            end
            S_OPANS: begin
                if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_ANS;
                    o_cmd.status = ST_DONE;
                    o_cmd.last   = 1'b1;
                    o_cmd.src    = SRC_TAG_IDX;
                    n_state = S_IDLE;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_FINIT;
                end
            end
            S_FINIT: begin
                o_cmd.find_init = 1'b1;
                n_state = (i_sts.func == FN_READ) ? S_FIND : S_VINIT;
            end
            S_FIND: begin
                if (i_sts.p_nil) begin
                    n_state = S_VINIT;
                end else if (i_sts.match) begin
                    o_cmd.take_p = 1'b1;
                    n_hit   = 1'b1;
                    n_state = S_HIT;
                end else begin
                    o_cmd.walk_chain = 1'b1;
                end
            end
            S_HIT: begin
                if (!i_sts.e_valid) begin
                    if (out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.kind      = KIND_RD;
                        o_cmd.status    = ST_HIT;
                        o_cmd.src       = SRC_IN_E;
                        o_cmd.set_valid = 1'b1;
                    end
                end else begin
                    o_cmd.lru_head = 1'b1;
                    o_cmd.set_busy = 1'b1;
                    n_state = S_ANS;
                end
            end
            S_VINIT: begin
                o_cmd.vic_init = 1'b1;
                n_state = S_VSCAN;
            end
            S_VSCAN: begin
                if (!i_sts.p_nil && i_sts.vic_ok) begin
                    o_cmd.take_p = 1'b1;
                    n_state = S_VDIRTY;
                end else if (i_sts.p_nil) begin
                    if (i_sts.pass) begin
                        n_state = S_NOFREE;
                    end else begin
                        o_cmd.vic_pass2 = 1'b1;
                    end
                end else begin
                    o_cmd.walk_lru = 1'b1;
                end
            end
            S_NOFREE: begin
                if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_ANS;
                    o_cmd.status = ST_NOFREE;
                    o_cmd.last   = 1'b1;
                    o_cmd.src    = SRC_IN_Z;
                    n_state = S_IDLE;
                end
            end
            S_VDIRTY: begin
                if (!i_sts.e_dirty) begin
                    n_state = S_VTAB;
                end else if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_WR;
                    o_cmd.status = ST_HIT;
                    o_cmd.src    = SRC_TAG_E;
                    n_state = S_VTAB;
                end
            end
            S_VTAB: begin
                if (i_sts.e_in_table) begin
                    o_cmd.hash_tag = 1'b1;
                    n_state = S_RHASH;
                end else begin
                    n_state = S_RETAG;
                end
            end
            S_RHASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_RHEAD;
                end
            end
            S_RHEAD: begin
                if (i_sts.head_is_e) begin
                    o_cmd.rm_head = 1'b1;
                    n_state = S_RETAG;
                end else begin
                    o_cmd.rm_walk_init = 1'b1;
                    n_state = S_RWALK;
                end
            end
            S_RWALK: begin
                if (i_sts.p_nil) begin
                    n_state = S_RETAG;
                end else if (i_sts.next_is_e) begin
                    o_cmd.rm_link = 1'b1;
                    n_state = S_RETAG;
                end else begin
                    o_cmd.walk_chain = 1'b1;
                end
            end
            S_RETAG: begin
                if (i_sts.func != FN_READ) begin
                    o_cmd.retag = 1'b1;
                    n_state = S_VLRU;
                end else if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_RD;
                    o_cmd.status = ST_HIT;
                    o_cmd.src    = SRC_IN_E;
                    o_cmd.retag  = 1'b1;
                    n_state = S_VLRU;
                end
            end
            S_VLRU: begin
                o_cmd.lru_head = 1'b1;
                n_state = S_ANS;
            end
            S_ANS: begin
                if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_ANS;
                    o_cmd.status = r_hit ? ST_HIT :
                                   (i_sts.func == FN_READ) ? ST_MISS : ST_ALLOC;
                    o_cmd.last   = 1'b1;
                    o_cmd.src    = SRC_IN_E;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hit     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hit     <= n_hit;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

>>> hdl/lbbc_dpath.sv
module lbbc_dpath
    import lbbc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int DEVICE_BITS = DEVICE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_block_number,
    input  logic [3:0]  i_entry_index,
    input  logic        i_write_ok,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_out_entry,
    output logic [7:0]  o_out_device,
    output logic [31:0] o_out_block,
    output logic [2:0]  o_status,
    output logic        o_last
);

    localparam int IW = $clog2(ENTRIES);
    localparam int EW = $clog2(ENTRIES + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HL = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam logic [EW-1:0] NIL = EW'(ENTRIES);
    localparam logic [7:0] DEV_MASK =
        (DEVICE_BITS >= 8) ? 8'hFF : 8'((1 << DEVICE_BITS) - 1);
    // rounded-up reciprocal of the bucket count, exact for any 32-bit sum
    localparam logic [63:0] RECIP =
        ((64'd1 << (32 + HL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [15:0] RCP_LO = RECIP[15:0];
    localparam logic [16:0] RCP_HI = RECIP[32:16];

    logic [7:0]    r_tag_dev [ENTRIES];
    logic [31:0]   r_tag_blk [ENTRIES];
    logic [ENTRIES-1:0] r_valid, r_busy, r_dirty, r_in_table;
    logic [EW-1:0] r_next  [ENTRIES];
    logic [EW-1:0] r_bhead [BUCKETS];
    logic [EW-1:0] r_older [ENTRIES];
    logic [EW-1:0] r_newer [ENTRIES];
    logic [EW-1:0] r_lru_head, r_lru_tail;

    logic [2:0]    r_func;
    logic [7:0]    r_dev;
    logic [31:0]   r_blk;
    logic [3:0]    r_idx;
    logic          r_ok;
    logic [31:0]   r_sum;
    logic [65:0]   r_acc;
    logic [7:0]    r_rem;
    logic [1:0]    r_hcnt;
    logic [BW-1:0] r_hin;
    logic [EW-1:0] r_p, r_e, r_cnt;
    logic          r_pass;

    logic [1:0]    r_o_kind;
    logic [3:0]    r_o_entry;
    logic [7:0]    r_o_dev;
    logic [31:0]   r_o_blk;
    logic [2:0]    r_o_status;
    logic          r_o_last;

    logic [IW-1:0] pi, ei, xi;
    logic [BW-1:0] rb;
    logic [47:0]   prod_lo;
    logic [48:0]   prod_hi;
    logic [31:0]   quo, quo_b, rem_full;
    logic [7:0]    dev_in;
    logic [31:0]   sum_in, sum_tag;
    logic [EW-1:0] lo, lw, lhp;
    logic [3:0]    sel_entry;
    logic [7:0]    sel_dev;
    logic [31:0]   sel_blk;

    assign pi = r_p[IW-1:0];
    assign ei = r_e[IW-1:0];
    assign xi = IW'(r_idx);
    assign rb = r_rem[BW-1:0];

    assign dev_in  = i_device_id & DEV_MASK;
    assign sum_in  = 32'(dev_in) * 32'(HASH_MULT) + i_block_number;
    assign sum_tag = 32'(r_tag_dev[ei]) * 32'(HASH_MULT) + r_tag_blk[ei];

    // bucket = sum - floor(sum / BUCKETS) * BUCKETS, quotient by reciprocal
    assign prod_lo  = 48'(r_sum) * 48'(RCP_LO);
    assign prod_hi  = 49'(r_sum) * 49'(RCP_HI);
    assign quo      = 32'(r_acc >> (32 + HL));
    assign quo_b    = quo * 32'(BUCKETS);
    assign rem_full = r_sum - quo_b;

    always_comb begin
        lo  = r_older[ei];
        lw  = r_newer[ei];
        lhp = (lw < NIL) ? r_lru_head : lo;
    end

    always_comb begin
        o_sts.func       = r_func;
        o_sts.hash_last  = (r_hcnt == 2'd2);
        o_sts.p_nil      = (r_p >= NIL) || (r_cnt == NIL);
        o_sts.match      = (r_tag_dev[pi] == r_dev) && (r_tag_blk[pi] == r_blk);
        o_sts.vic_ok     = !r_busy[pi] && (r_pass || !r_dirty[pi]);
        o_sts.pass       = r_pass;
        o_sts.e_valid    = r_valid[ei];
        o_sts.e_dirty    = r_dirty[ei];
        o_sts.e_in_table = r_in_table[ei];
        o_sts.head_is_e  = (r_bhead[rb] == r_e);
        o_sts.next_is_e  = (r_next[pi] == r_e);
        o_sts.idx_oob    = (9'(r_idx) >= 9'(ENTRIES));
        o_sts.idx_dirty  = r_dirty[xi];
    end

    always_comb begin
        case (i_cmd.src)
            SRC_IN_E: begin
                sel_entry = 4'(r_e);
                sel_dev   = r_dev;
                sel_blk   = r_blk;
            end
            SRC_IN_Z: begin
                sel_entry = '0;
                sel_dev   = r_dev;
                sel_blk   = r_blk;
            end
            SRC_TAG_E: begin
                sel_entry = 4'(r_e);
                sel_dev   = r_tag_dev[ei];
                sel_blk   = r_tag_blk[ei];
            end
            SRC_TAG_IDX: begin
                sel_entry = r_idx;
                sel_dev   = r_tag_dev[xi];
                sel_blk   = r_tag_blk[xi];
            end
            SRC_IDX_Z: begin
                sel_entry = r_idx;
                sel_dev   = '0;
                sel_blk   = '0;
            end
            default: begin
                sel_entry = '0;
                sel_dev   = '0;
                sel_blk   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_busy     <= '0;
            r_dirty    <= '0;
            r_in_table <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_tag_dev[i] <= '0;
                r_tag_blk[i] <= '0;
                r_next[i]    <= NIL;
                r_older[i]   <= (i == 0) ? NIL : EW'(i - 1);
                r_newer[i]   <= (i == ENTRIES - 1) ? NIL : EW'(i + 1);
            end
            for (int b = 0; b < BUCKETS; b++) begin
                r_bhead[b] <= NIL;
            end
            r_lru_head <= EW'(ENTRIES - 1);
            r_lru_tail <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_func <= i_func;
                r_dev  <= dev_in;
                r_blk  <= i_block_number;
                r_idx  <= i_entry_index;
                r_ok   <= i_write_ok;
                r_sum  <= sum_in;
                r_rem  <= '0;
                r_hcnt <= '0;
            end
            if (i_cmd.hash_tag) begin
                r_sum  <= sum_tag;
                r_rem  <= '0;
                r_hcnt <= '0;
            end
            if (i_cmd.hash_step) begin
                case (r_hcnt)
                    2'd0: begin
                        r_acc <= 66'(prod_lo);
                    end
                    2'd1: begin
                        r_acc <= r_acc + {1'b0, prod_hi, 16'd0};
                    end
                    default: begin
                        r_rem <= rem_full[7:0];
                    end
                endcase
                r_hcnt <= r_hcnt + 2'd1;
            end
            if (i_cmd.find_init) begin
                r_p   <= r_bhead[rb];
                r_hin <= rb;
                r_cnt <= '0;
            end
            if (i_cmd.rm_walk_init) begin
                r_p   <= r_bhead[rb];
                r_cnt <= '0;
            end
            if (i_cmd.walk_chain) begin
                r_p   <= r_next[pi];
                r_cnt <= r_cnt + EW'(1);
            end
            if (i_cmd.walk_lru) begin
                r_p   <= r_newer[pi];
                r_cnt <= r_cnt + EW'(1);
            end
            if (i_cmd.vic_init || i_cmd.vic_pass2) begin
                r_p    <= r_lru_tail;
                r_cnt  <= '0;
                r_pass <= i_cmd.vic_pass2;
            end
            if (i_cmd.take_p) begin
                r_e <= r_p;
            end
            if (i_cmd.set_valid) begin
                r_valid[ei] <= 1'b1;
            end
            if (i_cmd.set_busy) begin
                r_busy[ei] <= 1'b1;
            end
            if (i_cmd.lru_head && r_lru_head != r_e) begin
                if (lo < NIL) begin
                    r_newer[lo[IW-1:0]] <= lw;
                end else begin
                    r_lru_tail <= lw;
                end
                if (lw < NIL) begin
                    r_older[lw[IW-1:0]] <= lo;
                end
                r_older[ei] <= lhp;
                r_newer[ei] <= NIL;
                if (lhp < NIL) begin
                    r_newer[lhp[IW-1:0]] <= r_e;
                end else begin
                    r_lru_tail <= r_e;
                end
                r_lru_head <= r_e;
            end
            if (i_cmd.op_apply) begin
                case (r_func)
                    FN_WBACK: begin
                        if (r_ok) begin
                            r_dirty[xi] <= 1'b0;
                        end
                    end
                    FN_REL: begin
                        r_busy[xi] <= 1'b0;
                    end
                    FN_DIRTY: begin
                        r_dirty[xi] <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.rm_head) begin
                r_bhead[rb] <= r_next[ei];
            end
            if (i_cmd.rm_link) begin
                r_next[pi] <= r_next[ei];
            end
            if (i_cmd.retag) begin
                r_tag_dev[ei]  <= r_dev;
                r_tag_blk[ei]  <= r_blk;
                r_valid[ei]    <= (r_func == FN_READ);
                r_busy[ei]     <= 1'b1;
                r_dirty[ei]    <= 1'b0;
                r_next[ei]     <= r_bhead[r_hin];
                r_bhead[r_hin] <= r_e;
                r_in_table[ei] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind   <= i_cmd.kind;
            r_o_entry  <= sel_entry;
            r_o_dev    <= sel_dev;
            r_o_blk    <= sel_blk;
            r_o_status <= i_cmd.status;
            r_o_last   <= i_cmd.last;
        end
    end

    assign o_kind       = r_o_kind;
    assign o_out_entry  = r_o_entry;
    assign o_out_device = r_o_dev;
    assign o_out_block  = r_o_blk;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

endmodule

>>> hdl/lru_block_buffer_cache_core.sv
// Tag and LRU replacement controller for a hashed disk block cache. One word
// is taken at a time; the input side is ready only while the block is idle,
// and a result word waiting in the output register does not hold off the next
// input. Every read or alloc first reduces (device*31 + block) to a bucket
// with a reciprocal multiply, a low and a high partial product and then the
// remainder; a read then walks its chain, one entry a cycle. A miss or alloc
// scans the LRU list from the tail, one entry a cycle, up to two passes, and
// an evicted entry still in a chain costs a second hash plus, unless it heads
// the chain, a chain walk. A read hit on an entry not yet valid first issues
// a disk read. A new result word waits until the one before it is taken. Each
// input yields disk requests first and then one answer word with tlast set.
module lru_block_buffer_cache_core
    import lbbc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int DEVICE_BITS = DEVICE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // device_id[7:0], block_number[39:8], entry_index[43:40], write_ok[44]
    input  logic [47:0] i_s_tdata,
    // func[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_entry[3:0], out_device[11:4], out_block[43:12], status[46:44]
    output logic [47:0] o_m_tdata,
    // kind[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    t_cmd        cmd;
    t_sts        sts;
    logic [3:0]  out_entry;
    logic [7:0]  out_device;
    logic [31:0] out_block;
    logic [2:0]  status;

    lbbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lbbc_dpath #(
        .ENTRIES     (ENTRIES),
        .BUCKETS     (BUCKETS),
        .DEVICE_BITS (DEVICE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_s_tuser),
        .i_device_id    (i_s_tdata[7:0]),
        .i_block_number (i_s_tdata[39:8]),
        .i_entry_index  (i_s_tdata[43:40]),
        .i_write_ok     (i_s_tdata[44]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_kind         (o_m_tuser),
        .o_out_entry    (out_entry),
        .o_out_device   (out_device),
        .o_out_block    (out_block),
        .o_status       (status),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, status, out_block, out_device, out_entry};

endmodule

>>> hdl/lbbc_checker.sv
module lbbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    // one input word at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while previous word in work");

    // answers close the run, requests never do
    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == 2'd0) == o_m_tlast))
        else $error("tlast does not match answer kind");

    // a pending disk request means the answer is still to come
    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready before answer");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 2'd3)
        else $error("bad result kind");

endmodule

bind lru_block_buffer_cache_core lbbc_checker u_lbbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
